### sv/assert_macros.svh
// Assertion macros for the RTL of the priority queue.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/mlpq_pkg.sv
// Constants and types for the multi-level priority queue.
// No dependencies; used by multi_level_priority_queue.
package mlpq_pkg;

  localparam int LEVELS       = 8;
  localparam int QUEUE_DEPTH  = 512;
  localparam int DATA_WIDTH   = 32;
  localparam int LVL_W        = 3;
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W       = LVL_W + PTR_W;
  localparam int MEM_DEPTH    = LEVELS * QUEUE_DEPTH;
  localparam int NUM_LEVELS_W = 4;
  localparam int STATUS_W     = 3;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [STATUS_W-1:0]   status_t;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_REMOVED   = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_BAD_LEVEL = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

endpackage

### sv/multi_level_priority_queue.sv
// Multi-level strict-priority queue: one circular FIFO per level in a shared store.
// Depends on mlpq_pkg and assert_macros.svh.
//
// Usage:
//   Requests: a transfer happens at a rising edge with start high and busy low.
//   in_req_type selects insert (word in_item_in into level in_level) or remove
//   (oldest word of the lowest-numbered non-empty level in use).
//   Results: exactly one per request, shown for one cycle with out_valid high,
//   in the cycle after the request transfer. The receiver cannot stall; results
//   must be taken as they appear.
//   Throughput: one request per cycle while busy is low. The result word comes
//   from the registered read port of the entry store.
//   Configuration: cfg_data (number of levels in use) is written at an edge
//   with cfg_valid and cfg_ready high. The user must write it only while no
//   request is in flight; the block does not enforce this. Reset (rst_n low,
//   synchronous): all levels empty, 8 levels in use, no result pending; busy
//   is held high and cfg_ready low until the busy register clears after reset;
//   the store is not cleared, and entries are read only after they were written.
module multi_level_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_req_type,
  input  logic [mlpq_pkg::DATA_WIDTH-1:0]     in_item_in,
  input  logic [mlpq_pkg::LVL_W-1:0]          in_level,
  output logic                                out_valid,
  output logic [mlpq_pkg::DATA_WIDTH-1:0]     out_item_out,
  output logic [mlpq_pkg::LVL_W-1:0]          out_served_level,
  output logic [mlpq_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_all_empty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mlpq_pkg::NUM_LEVELS_W-1:0]   cfg_data
);

  `include "assert_macros.svh"

  localparam int L = mlpq_pkg::LEVELS;

  logic                               busy_r;
  logic [mlpq_pkg::NUM_LEVELS_W-1:0]  num_levels_r;
  mlpq_pkg::ptr_t                     head_r [L];
  mlpq_pkg::ptr_t                     head_nxt [L];
  mlpq_pkg::ptr_t                     tail_r [L];
  mlpq_pkg::ptr_t                     tail_nxt [L];
  mlpq_pkg::cnt_t                     count_r [L];
  mlpq_pkg::cnt_t                     count_nxt [L];
  mlpq_pkg::data_t                    mem [mlpq_pkg::MEM_DEPTH];
  mlpq_pkg::data_t                    rd_data_r;

  logic                               out_valid_r;
  logic                               hit_r;
  logic [mlpq_pkg::LVL_W-1:0]         served_r;
  mlpq_pkg::status_t                  status_r;
  mlpq_pkg::status_t                  status_nxt;
  logic                               all_empty_r;
  logic                               all_empty_nxt;

  logic                               acc;
  logic [mlpq_pkg::NUM_LEVELS_W-1:0]  act_n;
  logic [L-1:0]                       active;
  logic [L-1:0]                       full;
  logic [L-1:0]                       avail;
  logic [L-1:0]                       nonempty_nxt;
  logic [mlpq_pkg::LVL_W-1:0]         pop_lvl;
  logic                               in_range;
  logic                               do_ins;
  logic                               do_pop;
  logic [mlpq_pkg::ADDR_W-1:0]        wr_addr;
  logic [mlpq_pkg::ADDR_W-1:0]        rd_addr;

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign acc       = start && !busy_r;

  always_comb begin
    act_n = (num_levels_r > mlpq_pkg::NUM_LEVELS_W'(L)) ? mlpq_pkg::NUM_LEVELS_W'(L)
                                                         : num_levels_r;
    for (int i = 0; i < L; i++) begin
      active[i] = mlpq_pkg::NUM_LEVELS_W'(i) < act_n;
      full[i]   = count_r[i] == mlpq_pkg::CNT_W'(mlpq_pkg::QUEUE_DEPTH);
      avail[i]  = active[i] && (count_r[i] != '0);
    end
    pop_lvl = '0;
    for (int i = L - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pop_lvl = mlpq_pkg::LVL_W'(i);
      end
    end
    in_range = {1'b0, in_level} < act_n;
    do_ins   = acc && (in_req_type == mlpq_pkg::REQ_INSERT) && in_range && !full[in_level];
    do_pop   = acc && (in_req_type == mlpq_pkg::REQ_REMOVE) && (|avail);
    wr_addr  = {in_level, tail_r[in_level]};
    rd_addr  = {pop_lvl, head_r[pop_lvl]};

    priority if (in_req_type == mlpq_pkg::REQ_INSERT) begin
      priority if (!in_range) status_nxt = mlpq_pkg::ST_BAD_LEVEL;
      else if (full[in_level]) status_nxt = mlpq_pkg::ST_FULL;
      else                     status_nxt = mlpq_pkg::ST_INSERTED;
    end else if (|avail) begin
      status_nxt = mlpq_pkg::ST_REMOVED;
    end else begin
      status_nxt = mlpq_pkg::ST_EMPTY;
    end

    for (int i = 0; i < L; i++) begin
      head_nxt[i]  = head_r[i];
      tail_nxt[i]  = tail_r[i];
      count_nxt[i] = count_r[i];
      if (do_ins && (in_level == mlpq_pkg::LVL_W'(i))) begin
        tail_nxt[i]  = tail_r[i] + 1'b1;
        count_nxt[i] = count_r[i] + 1'b1;
      end
      if (do_pop && (pop_lvl == mlpq_pkg::LVL_W'(i))) begin
        head_nxt[i]  = head_r[i] + 1'b1;
        count_nxt[i] = count_r[i] - 1'b1;
      end
      nonempty_nxt[i] = count_nxt[i] != '0;
    end
    all_empty_nxt = !(|(nonempty_nxt & active));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      num_levels_r <= mlpq_pkg::NUM_LEVELS_W'(8);
      out_valid_r  <= 1'b0;
      for (int i = 0; i < L; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= acc;
      if (cfg_valid && cfg_ready) begin
        num_levels_r <= cfg_data;
      end
      for (int i = 0; i < L; i++) begin
        head_r[i]  <= head_nxt[i];
        tail_r[i]  <= tail_nxt[i];
        count_r[i] <= count_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      mem[wr_addr] <= in_item_in;
    end
    if (do_pop) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hit_r       <= do_pop;
      served_r    <= do_pop ? pop_lvl : '0;
      status_r    <= status_nxt;
      all_empty_r <= all_empty_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_item_out     = hit_r ? rd_data_r : '0;
  assign out_served_level = served_r;
  assign out_status       = status_r;
  assign out_all_empty    = all_empty_r;

  `CHK_NEXT(a_latency, clk, rst_n, acc, out_valid_r)
  `CHK_IMPL(a_removed_was_remove, clk, rst_n,
            out_valid_r && (status_r == mlpq_pkg::ST_REMOVED), $past(in_req_type) == mlpq_pkg::REQ_REMOVE)
  `CHK_IMPL(a_empty_status, clk, rst_n,
            out_valid_r && (status_r == mlpq_pkg::ST_EMPTY), all_empty_r)
  `CHK_IMPL(a_no_word_unless_removed, clk, rst_n,
            out_valid_r && (status_r != mlpq_pkg::ST_REMOVED), (out_item_out == '0) && (served_r == '0))

endmodule

### bench/multi_level_priority_queue_tb.sv
// Self-checking bench for multi_level_priority_queue: directed and random insert/remove
// traffic over several level settings, checked against an in-bench queue predictor.
// Depends on mlpq_pkg and the RTL of multi_level_priority_queue.
module multi_level_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic                       kind;
    mlpq_pkg::data_t            data;
    logic [mlpq_pkg::LVL_W-1:0] lvl;
  } request_t;

  typedef struct packed {
    mlpq_pkg::data_t            item;
    logic [mlpq_pkg::LVL_W-1:0] served;
    mlpq_pkg::status_t          status;
    logic                       all_empty;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = mlpq_pkg::REQ_INSERT;
  mlpq_pkg::data_t in_item_in = '0;
  logic [mlpq_pkg::LVL_W-1:0] in_level = '0;
  logic out_valid;
  mlpq_pkg::data_t out_item_out;
  logic [mlpq_pkg::LVL_W-1:0] out_served_level;
  mlpq_pkg::status_t out_status;
  logic out_all_empty;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mlpq_pkg::NUM_LEVELS_W-1:0] cfg_data = '0;

  request_t  request_backlog[$];
  response_t pending_responses[$];

  mlpq_pkg::data_t level_words[mlpq_pkg::LEVELS][mlpq_pkg::QUEUE_DEPTH];
  mlpq_pkg::ptr_t  rd_ptr[mlpq_pkg::LEVELS] = '{default: '0};
  mlpq_pkg::ptr_t  wr_ptr[mlpq_pkg::LEVELS] = '{default: '0};
  mlpq_pkg::cnt_t  fill[mlpq_pkg::LEVELS] = '{default: '0};
  int unsigned levels_in_use = 8;

  int fault_count = 0;
  int idle_cycles = 0;
  int burst_cnt = 1;
  int gap_cnt = 0;
  response_t got_rsp;
  response_t want_rsp;

  multi_level_priority_queue dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_item_in(in_item_in),
    .in_level(in_level),
    .out_valid(out_valid),
    .out_item_out(out_item_out),
    .out_served_level(out_served_level),
    .out_status(out_status),
    .out_all_empty(out_all_empty),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic response_t serve_request(request_t r);
    response_t rsp;
    int unsigned n;
    int unsigned i;
    logic found;
    n = (levels_in_use > mlpq_pkg::LEVELS) ? mlpq_pkg::LEVELS : levels_in_use;
    rsp = '{item: '0, served: '0, status: mlpq_pkg::ST_EMPTY, all_empty: 1'b1};
    found = 1'b0;
    if (r.kind == mlpq_pkg::REQ_INSERT) begin
      if (r.lvl >= n) begin
        rsp.status = mlpq_pkg::ST_BAD_LEVEL;
      end else if (fill[r.lvl] >= mlpq_pkg::QUEUE_DEPTH) begin
        rsp.status = mlpq_pkg::ST_FULL;
      end else begin
        level_words[r.lvl][wr_ptr[r.lvl]] = r.data;
        wr_ptr[r.lvl] = wr_ptr[r.lvl] + 1'b1;
        fill[r.lvl] = fill[r.lvl] + 1'b1;
        rsp.status = mlpq_pkg::ST_INSERTED;
      end
    end else begin
      for (i = 0; i < n; i++) begin
        if (!found && fill[i] != 0) begin
          found = 1'b1;
          rsp.item = level_words[i][rd_ptr[i]];
          rsp.served = i[mlpq_pkg::LVL_W-1:0];
          rsp.status = mlpq_pkg::ST_REMOVED;
          rd_ptr[i] = rd_ptr[i] + 1'b1;
          fill[i] = fill[i] - 1'b1;
        end
      end
    end
    for (i = 0; i < n; i++)
      if (fill[i] != 0) rsp.all_empty = 1'b0;
    return rsp;
  endfunction

  // driver: bursts of transfers with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_responses.push_back(serve_request(request_backlog.pop_front()));
      end
      if (start && busy) begin
        // hold the current request
      end else if (gap_cnt != 0) begin
        start <= 1'b0;
        gap_cnt--;
      end else if (request_backlog.size() != 0) begin
        start <= 1'b1;
        in_req_type <= request_backlog[0].kind;
        in_item_in <= request_backlog[0].data;
        in_level <= request_backlog[0].lvl;
        if (burst_cnt <= 1) begin
          burst_cnt = ($urandom_range(4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
          gap_cnt = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_cnt--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      got_rsp = '{item: out_item_out, served: out_served_level, status: out_status,
                  all_empty: out_all_empty};
      if (pending_responses.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected result: item=%h lvl=%0d status=%0d empty=%0b",
                   got_rsp.item, got_rsp.served, got_rsp.status, got_rsp.all_empty);
        fault_count++;
      end else begin
        want_rsp = pending_responses.pop_front();
        if (got_rsp.item !== want_rsp.item || got_rsp.served !== want_rsp.served ||
            got_rsp.status !== want_rsp.status ||
            got_rsp.all_empty !== want_rsp.all_empty) begin
          if (fault_count < 10)
            $display({"mismatch: exp item=%h lvl=%0d status=%0d empty=%0b",
                      " | got item=%h lvl=%0d status=%0d empty=%0b"},
                     want_rsp.item, want_rsp.served, want_rsp.status, want_rsp.all_empty,
                     got_rsp.item, got_rsp.served, got_rsp.status, got_rsp.all_empty);
          fault_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_req(logic kind, mlpq_pkg::data_t data, int unsigned lvl);
    request_t r;
    r.kind = kind;
    r.data = data;
    r.lvl = lvl[mlpq_pkg::LVL_W-1:0];
    request_backlog.push_back(r);
  endtask

  task automatic drain();
    while (request_backlog.size() != 0 || pending_responses.size() != 0 || start)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_levels(int unsigned v);
    drain();
    cfg_data <= v[mlpq_pkg::NUM_LEVELS_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    levels_in_use = v;
  endtask

  task automatic queue_random(int count, int insert_pct, int lvl0_pct);
    int k;
    for (k = 0; k < count; k++)
      push_req(($urandom_range(99) < insert_pct) ? mlpq_pkg::REQ_INSERT : mlpq_pkg::REQ_REMOVE,
               $urandom, ($urandom_range(99) < lvl0_pct) ? 0 : $urandom_range(7));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: eight levels
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, $urandom_range(7));
    push_req(mlpq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 7);
    push_req(mlpq_pkg::REQ_INSERT, 32'h0000_0000, 3);
    push_req(mlpq_pkg::REQ_INSERT, 32'hA5A5_A5A5, 0);
    push_req(mlpq_pkg::REQ_INSERT, 32'h5A5A_5A5A, 0);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 7);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 0);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 5);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 2);
    push_req(mlpq_pkg::REQ_INSERT, 32'h1234_5678, 5);
    push_req(mlpq_pkg::REQ_INSERT, 32'h8000_0001, 1);

    // levels above the setting keep their words but are not served
    write_levels(3);
    push_req(mlpq_pkg::REQ_INSERT, $urandom, 5);
    push_req(mlpq_pkg::REQ_INSERT, 32'hDEAD_BEEF, 2);
    push_req(mlpq_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 7);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 0);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 3);

    write_levels(0);
    push_req(mlpq_pkg::REQ_INSERT, $urandom, 0);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 0);

    // setting above the level count acts as all levels
    write_levels(15);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 1);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 6);
    push_req(mlpq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 7);
    push_req(mlpq_pkg::REQ_REMOVE, $urandom, 4);

    // single level: fill past full, wrapping the write pointer, then remove-heavy traffic
    write_levels(1);
    queue_random(540, 100, 100);
    queue_random(200, 20, 95);
    write_levels(8);
    queue_random(250, 55, 40);
    write_levels($urandom_range(2, 7));
    queue_random(150, 40, 30);
    write_levels(0);
    queue_random(15, 50, 50);
    write_levels(8);
    queue_random(200, 30, 30);

    drain();
    if (fault_count == 0 && pending_responses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### multi_level_priority_queue.f
+incdir+sv
sv/mlpq_pkg.sv
sv/multi_level_priority_queue.sv
bench/multi_level_priority_queue_tb.sv
